>>> sv/mhce_pkg.sv
// package for the masked height cell evaluator: payload types and constants
`timescale 1ns / 1ps
`default_nettype none

package mhce_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int CORNERS   = 4;
    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = 32;
    localparam int NUM_W     = 50;
    localparam int DEN_W     = 18;

    // register index taken from paddr[2]
    localparam logic REG_HEIGHT_SCALE = 1'b0;
    localparam logic REG_WEIGHT_LIMIT = 1'b1;

    localparam logic [15:0]        HEIGHT_SCALE_RESET = 16'd256;
    localparam logic [15:0]        WEIGHT_LIMIT_RESET = 16'd1638;
    localparam logic signed [31:0] MIN_SEEN_RESET     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_SEEN_RESET     = 32'sh8000_0000;

    typedef struct packed {
        logic signed [15:0] height_a;
        logic signed [15:0] height_b;
        logic signed [15:0] height_c;
        logic signed [15:0] height_d;
        logic [15:0]        weight_a;
        logic [15:0]        weight_b;
        logic [15:0]        weight_c;
        logic [15:0]        weight_d;
        logic               frame_start;
    } mhce_in_t;

    typedef struct packed {
        logic               cell_kept;
        logic [3:0]         triangle_enables;
        logic signed [31:0] center_height;
        logic signed [31:0] scaled_a;
        logic signed [31:0] scaled_b;
        logic signed [31:0] scaled_c;
        logic signed [31:0] scaled_d;
        logic signed [31:0] running_min;
        logic signed [31:0] running_max;
    } mhce_out_t;

endpackage

`default_nettype wire

>>> sv/masked_height_cell_evaluator.sv
// masked height cell evaluator: bit-serial scaling, weighting and averaging of one cell
//
//  channel   ports                          direction  transaction
//  config    psel/penable/pwrite/paddr/...  in/out     register write or read
//  cell in   s_valid/s_ready/s_data         in         one cell, corners and weights
//  result    m_valid/m_ready/m_data         out        one evaluated cell
//
// after acceptance a cell passes through the shift-add height scaling, the
// height-weight products, the serial sums and min/max, taking the magnitude,
// the restoring divider and the load of the result; s_ready rises the cycle
// after the load, so no new cell is taken until its result is loaded.
// a stalled m_ready holds back the next cell only while its result waits to load.
// synchronous active-low reset loads the register defaults and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module masked_height_cell_evaluator import mhce_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire mhce_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mhce_out_t                  m_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_SCALE = 7'b000_0010,
        ST_WMUL  = 7'b000_0100,
        ST_SUM   = 7'b000_1000,
        ST_PREP  = 7'b001_0000,
        ST_DIV   = 7'b010_0000,
        ST_DONE  = 7'b100_0000
    } state_t;

    // fan triangle edges: a-b, b-d, d-c, c-a
    localparam logic [1:0] PAIR_FIRST  [CORNERS] = '{2'd0, 2'd1, 2'd3, 2'd2};
    localparam logic [1:0] PAIR_SECOND [CORNERS] = '{2'd1, 2'd3, 2'd2, 2'd0};

    state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] scale_reg, limit_reg;
    mhce_in_t    in_reg;

    logic signed [31:0] h_reg       [CORNERS];
    logic signed [31:0] h_next      [CORNERS];
    logic signed [32:0] lane_hi_reg [CORNERS];
    logic signed [32:0] lane_hi_next[CORNERS];
    logic [15:0]        lane_lo_reg [CORNERS];
    logic [15:0]        lane_lo_next[CORNERS];
    logic [16:0]        pair_hi_reg [CORNERS];
    logic [16:0]        pair_hi_next[CORNERS];
    logic [15:0]        pair_lo_reg [CORNERS];
    logic [15:0]        pair_lo_next[CORNERS];

    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DIV_STEPS-1:0]    quo_reg, quo_next;
    logic signed [31:0]      min_reg, min_next, max_reg, max_next;

    logic      out_valid_reg, out_valid_next;
    mhce_out_t out_reg, out_next;

    logic signed [15:0] raw_in [CORNERS];
    logic [15:0]        w_in   [CORNERS];
    logic [15:0]        s_w    [CORNERS];
    logic               kept;
    logic               cfg_wr;
    logic               in_accept;

    assign raw_in[0] = in_reg.height_a;
    assign raw_in[1] = in_reg.height_b;
    assign raw_in[2] = in_reg.height_c;
    assign raw_in[3] = in_reg.height_d;
    assign w_in[0]   = in_reg.weight_a;
    assign w_in[1]   = in_reg.weight_b;
    assign w_in[2]   = in_reg.weight_c;
    assign w_in[3]   = in_reg.weight_d;
    assign s_w[0]    = s_data.weight_a;
    assign s_w[1]    = s_data.weight_b;
    assign s_w[2]    = s_data.weight_c;
    assign s_w[3]    = s_data.weight_d;

    assign kept = (w_in[0] > limit_reg) || (w_in[1] > limit_reg) ||
                  (w_in[2] > limit_reg) || (w_in[3] > limit_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_HEIGHT_SCALE: prdata = {16'd0, scale_reg};
            REG_WEIGHT_LIMIT: prdata = {16'd0, limit_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= HEIGHT_SCALE_RESET;
            limit_reg <= WEIGHT_LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_HEIGHT_SCALE: scale_reg <= pwdata[15:0];
                REG_WEIGHT_LIMIT: limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [32:0]      mc;
        logic signed [32:0]      sum;
        logic [16:0]             psum;
        logic [1:0]              idx;
        logic signed [NUM_W-1:0] term;
        logic [NUM_W-1:0]        mag;
        logic [DEN_W:0]          trial;
        logic                    qbit;
        logic [31:0]             prod;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        out_next   = out_reg;
        for (int i = 0; i < CORNERS; i++) begin
            h_next[i]       = h_reg[i];
            lane_hi_next[i] = lane_hi_reg[i];
            lane_lo_next[i] = lane_lo_reg[i];
            pair_hi_next[i] = pair_hi_reg[i];
            pair_lo_next[i] = pair_lo_reg[i];
        end
        mc    = '0;
        sum   = '0;
        psum  = '0;
        idx   = cnt_reg[1:0];
        term  = '0;
        mag   = '0;
        trial = '0;
        qbit  = 1'b0;
        prod  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCALE;
                    cnt_next   = '0;
                    num_next   = '0;
                    den_next   = '0;
                    for (int i = 0; i < CORNERS; i++) begin
                        lane_hi_next[i] = '0;
                        lane_lo_next[i] = scale_reg;
                        pair_hi_next[i] = '0;
                        pair_lo_next[i] = s_w[PAIR_FIRST[i]];
                    end
                    if (s_data.frame_start) begin
                        min_next = MIN_SEEN_RESET;
                        max_next = MAX_SEEN_RESET;
                    end
                end
            end
            ST_SCALE: begin
                for (int i = 0; i < CORNERS; i++) begin
                    // shift-add: one multiplier bit per cycle, lsb first
                    mc  = {{17{raw_in[i][15]}}, raw_in[i]};
                    sum = lane_lo_reg[i][0] ? lane_hi_reg[i] + mc : lane_hi_reg[i];
                    lane_hi_next[i] = {sum[32], sum[32:1]};
                    lane_lo_next[i] = {sum[0], lane_lo_reg[i][15:1]};
                    psum = pair_lo_reg[i][0] ?
                           pair_hi_reg[i] + {1'b0, w_in[PAIR_SECOND[i]]} : pair_hi_reg[i];
                    pair_hi_next[i] = {1'b0, psum[16:1]};
                    pair_lo_next[i] = {psum[0], pair_lo_reg[i][15:1]};
                    if (cnt_reg == 5'(MUL_STEPS - 1)) begin
                        h_next[i]       = {sum[16:1], sum[0], lane_lo_reg[i][15:1]};
                        lane_hi_next[i] = '0;
                        lane_lo_next[i] = w_in[i];
                    end
                end
                if (cnt_reg == 5'(MUL_STEPS - 1)) begin
                    state_next = ST_WMUL;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_WMUL: begin
                for (int i = 0; i < CORNERS; i++) begin
                    mc  = {h_reg[i][31], h_reg[i]};
                    sum = lane_lo_reg[i][0] ? lane_hi_reg[i] + mc : lane_hi_reg[i];
                    lane_hi_next[i] = {sum[32], sum[32:1]};
                    lane_lo_next[i] = {sum[0], lane_lo_reg[i][15:1]};
                end
                if (cnt_reg == 5'(MUL_STEPS - 1)) begin
                    state_next = ST_SUM;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SUM: begin
                // one corner per cycle into the sums, and into the running extremes when the cell is kept
                term     = {lane_hi_reg[idx][32], lane_hi_reg[idx], lane_lo_reg[idx]};
                num_next = num_reg + term;
                den_next = den_reg + {2'b00, w_in[idx]};
                if (kept) begin
                    if (h_reg[idx] < min_reg) min_next = h_reg[idx];
                    if (h_reg[idx] > max_reg) max_next = h_reg[idx];
                end
                if (cnt_reg == 5'(CORNERS - 1)) begin
                    state_next = ST_PREP;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_PREP: begin
                // magnitude divide, quotient fits 32 bits so the top bits start as remainder
                neg_next   = num_reg[NUM_W-1];
                mag        = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                rem_next   = mag[NUM_W-1:DIV_STEPS];
                quo_next   = mag[DIV_STEPS-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                trial = {rem_reg, quo_reg[DIV_STEPS-1]};
                qbit  = (trial >= {1'b0, den_reg});
                if (qbit) begin
                    rem_next = DEN_W'(trial - {1'b0, den_reg});
                end else begin
                    rem_next = trial[DEN_W-1:0];
                end
                quo_next = {quo_reg[DIV_STEPS-2:0], qbit};
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next = '0;
                    if (kept) begin
                        out_next.cell_kept = 1'b1;
                        for (int i = 0; i < CORNERS; i++) begin
                            prod = {pair_hi_reg[i][15:0], pair_lo_reg[i]};
                            out_next.triangle_enables[i] = (prod > {1'b0, limit_reg, 15'd0});
                        end
                        if (den_reg == '0) begin
                            out_next.center_height = '0;
                        end else if (neg_reg) begin
                            out_next.center_height = -quo_reg;
                        end else begin
                            out_next.center_height = quo_reg;
                        end
                        out_next.scaled_a = h_reg[0];
                        out_next.scaled_b = h_reg[1];
                        out_next.scaled_c = h_reg[2];
                        out_next.scaled_d = h_reg[3];
                    end
                    out_next.running_min = min_reg;
                    out_next.running_max = max_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if ((state_reg == ST_DONE) && (!out_valid_reg || m_ready)) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            min_reg       <= MIN_SEEN_RESET;
            max_reg       <= MAX_SEEN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) in_reg <= s_data;
        for (int i = 0; i < CORNERS; i++) begin
            h_reg[i]       <= h_next[i];
            lane_hi_reg[i] <= lane_hi_next[i];
            lane_lo_reg[i] <= lane_lo_next[i];
            pair_hi_reg[i] <= pair_hi_next[i];
            pair_lo_reg[i] <= pair_lo_next[i];
        end
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
